/* hdl/srw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srw_pkg;

   localparam int SEQ_W      = 32;
   localparam int OP_W       = 3;
   localparam int CNT_W      = 6;
   localparam int WS_W       = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SEQUENCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL_ON_SLIDE  = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 3'd0,
      OP_MARK    = 3'd1,
      OP_ADVANCE = 3'd2,
      OP_SLIDE   = 3'd3,
      OP_LIST    = 3'd4,
      OP_RESET   = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_STATUS,
      ST_SLIDE_RD,
      ST_SLIDE_CHK,
      ST_FILL,
      ST_LIST_RD,
      ST_LIST_CHK,
      ST_LIST_END
   } state_type;

endpackage

`default_nettype wire

/* hdl/srw_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface srw_req_if;
   logic                       valid;
   logic                       ready;
   logic [srw_pkg::OP_W-1:0]   op;
   logic [srw_pkg::SEQ_W-1:0]  seq;

   modport source (output valid, output op, output seq, input ready);
   modport sink   (input valid, input op, input seq, output ready);
endinterface

`default_nettype wire

/* hdl/srw_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface srw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [srw_pkg::SEQ_W-1:0]  head_seq;
   logic [srw_pkg::CNT_W-1:0]  entry_count;
   logic                       is_full;
   logic                       is_empty;
   logic                       hit;
   logic [srw_pkg::CNT_W-1:0]  moved;
   logic                       resend_valid;
   logic [srw_pkg::SEQ_W-1:0]  resend_sequence;
   logic                       last;

   modport source (output valid, output head_seq, output entry_count, output is_full,
                   output is_empty, output hit, output moved, output resend_valid,
                   output resend_sequence, output last, input ready);
   modport sink   (input valid, input head_seq, input entry_count, input is_full,
                   input is_empty, input hit, input moved, input resend_valid,
                   input resend_sequence, input last, output ready);
endinterface

`default_nettype wire

/* hdl/selective_repeat_window.sv */
// Operations: push, mark, advance and unused codes give one result each; slide pops the
//   acknowledged entries at the front, stopping at an unacknowledged one, then refills the
//   window in receiver mode; reset op reloads the head and fills the window; list gives one
//   result per unacknowledged entry, the final one marked last. Output stalls delay them all.
// Throughput: one item at a time; the next item transfers in only after the final result
//   is loaded. Reset: synchronous, active high; empty window at head 0, register defaults.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_window #(
   parameter int MAX_WINDOW = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   srw_req_if.sink                              req_ch,
   srw_rsp_if.source                            rsp_ch,
   input  wire                                  csr_we,
   input  wire  [srw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [srw_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // slot index, entry count and a count wide enough for the 6-bit result fields
   localparam int SW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int EW = (CW > srw_pkg::CNT_W) ? CW : srw_pkg::CNT_W;

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   logic [srw_pkg::WS_W-1:0]   ws_ff, ws_in;
   logic [srw_pkg::SEQ_W-1:0]  init_ff, init_in;
   logic                       refill_ff, refill_in;

   always_comb begin
      ws_in     = ws_ff;
      init_in   = init_ff;
      refill_in = refill_ff;
      if (csr_we) begin
         case (csr_index)
            srw_pkg::CSR_WINDOW_SIZE:      ws_in     = csr_wdata[srw_pkg::WS_W-1:0];
            srw_pkg::CSR_INITIAL_SEQUENCE: init_in   = csr_wdata[srw_pkg::SEQ_W-1:0];
            srw_pkg::CSR_REFILL_ON_SLIDE:  refill_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff     <= srw_pkg::WS_W'(32);
         init_ff   <= '0;
         refill_ff <= 1'b0;
      end else begin
         ws_ff     <= ws_in;
         init_ff   <= init_in;
         refill_ff <= refill_in;
      end
   end

   // Effective size: zero reads as one, anything above the ring reads as the ring.
   logic [EW-1:0] ws_ext;
   logic [CW-1:0] eff_size;
   logic [CW-1:0] eff_m1;

   always_comb begin
      ws_ext = EW'(ws_ff);
      if (ws_ext == '0) begin
         ws_ext = EW'(1);
      end
      if (ws_ext > EW'(MAX_WINDOW)) begin
         ws_ext = EW'(MAX_WINDOW);
      end
      eff_size = CW'(ws_ext);
      eff_m1   = eff_size - CW'(1);
   end

   // Ring position of the entry k places behind base; the sum stays below twice the ring.
   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] base,
                                              input logic [CW-1:0] k);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(k);
      if (sum >= (CW+1)'(MAX_WINDOW)) begin
         sum = sum - (CW+1)'(MAX_WINDOW);
      end
      return sum[SW-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // Window state and the flag memory (one bit per slot, set = acknowledged)
   // ---------------------------------------------------------------------------
   srw_pkg::state_type         state_ff, state_in;
   srw_pkg::op_type            op_ff, op_in;
   logic [srw_pkg::SEQ_W-1:0]  seq_ff, seq_in;
   logic [srw_pkg::SEQ_W-1:0]  dist_ff, dist_in;     // seq minus head
   logic                       win_ff, win_in;       // seq lies inside the window
   logic [srw_pkg::SEQ_W-1:0]  head_ff, head_in;
   logic [SW-1:0]              front_ff, front_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       hit_ff, hit_in;
   logic [CW-1:0]              moved_ff, moved_in;
   logic [CW-1:0]              walk_ff, walk_in;     // list position
   logic                       pend_ff, pend_in;     // one resend result held back
   logic [srw_pkg::SEQ_W-1:0]  pend_seq_ff, pend_seq_in;

   logic                       flag_mem [MAX_WINDOW];
   logic                       mem_we;
   logic [SW-1:0]              mem_waddr;
   logic                       mem_wdata;
   logic                       mem_re;
   logic [SW-1:0]              mem_raddr;
   logic                       rd_flag_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         flag_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_flag_ff <= flag_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------------------
   // Result register: parts the walk from a stalled sink
   // ---------------------------------------------------------------------------
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_load;
   logic                       out_free;
   logic [srw_pkg::SEQ_W-1:0]  rsp_head_ff, rsp_head_in;
   logic [srw_pkg::CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                       rsp_full_ff, rsp_full_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [srw_pkg::CNT_W-1:0]  rsp_moved_ff, rsp_moved_in;
   logic                       rsp_rv_ff, rsp_rv_in;
   logic [srw_pkg::SEQ_W-1:0]  rsp_rs_ff, rsp_rs_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [EW-1:0]              count_ext;
   logic [EW-1:0]              moved_ext;
   logic [CW-1:0]              dist_small;
   logic [CW-1:0]              adv_n;
   logic [srw_pkg::SEQ_W-1:0]  diff;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign count_ext  = EW'(count_ff);
   assign moved_ext  = EW'(moved_ff);
   // only meaningful when the window test passed; then it is below the ring size
   assign dist_small = dist_ff[CW-1:0];
   assign adv_n      = (dist_small < count_ff) ? dist_small : count_ff;
   assign diff       = seq_ff - head_ff;

   assign req_ch.ready = (state_ff == srw_pkg::ST_IDLE);

   // ---------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srw_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = srw_pkg::ST_DECODE;
            end
         end
         srw_pkg::ST_DECODE: begin
            case (op_ff)
               srw_pkg::OP_SLIDE: state_in = srw_pkg::ST_SLIDE_RD;
               srw_pkg::OP_LIST:  state_in = srw_pkg::ST_LIST_RD;
               srw_pkg::OP_RESET: state_in = srw_pkg::ST_FILL;
               default:           state_in = srw_pkg::ST_EXEC;
            endcase
         end
         srw_pkg::ST_EXEC: state_in = srw_pkg::ST_STATUS;
         srw_pkg::ST_STATUS: begin
            if (out_free) begin
               state_in = srw_pkg::ST_IDLE;
            end
         end
         srw_pkg::ST_SLIDE_RD: begin
            if (count_ff == '0) begin
               state_in = refill_ff ? srw_pkg::ST_FILL : srw_pkg::ST_STATUS;
            end else begin
               state_in = srw_pkg::ST_SLIDE_CHK;
            end
         end
         srw_pkg::ST_SLIDE_CHK: begin
            if (rd_flag_ff) begin
               state_in = srw_pkg::ST_SLIDE_RD;
            end else begin
               state_in = refill_ff ? srw_pkg::ST_FILL : srw_pkg::ST_STATUS;
            end
         end
         srw_pkg::ST_FILL: begin
            if (count_ff >= eff_size) begin
               state_in = srw_pkg::ST_STATUS;
            end
         end
         srw_pkg::ST_LIST_RD: begin
            if (walk_ff == count_ff) begin
               state_in = srw_pkg::ST_LIST_END;
            end else begin
               state_in = srw_pkg::ST_LIST_CHK;
            end
         end
         srw_pkg::ST_LIST_CHK: begin
            // hold while an earlier resend result cannot leave
            if (rd_flag_ff || !pend_ff || out_free) begin
               state_in = srw_pkg::ST_LIST_RD;
            end
         end
         srw_pkg::ST_LIST_END: begin
            if (out_free) begin
               state_in = srw_pkg::ST_IDLE;
            end
         end
         default: state_in = srw_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath, memory access and result loading
   // ---------------------------------------------------------------------------
   always_comb begin
      op_in       = op_ff;
      seq_in      = seq_ff;
      dist_in     = dist_ff;
      win_in      = win_ff;
      head_in     = head_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      hit_in      = hit_ff;
      moved_in    = moved_ff;
      walk_in     = walk_ff;
      pend_in     = pend_ff;
      pend_seq_in = pend_seq_ff;

      mem_we    = 1'b0;
      mem_waddr = slot_add(front_ff, count_ff);
      mem_wdata = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = front_ff;

      rsp_load     = 1'b0;
      rsp_head_in  = head_ff;
      rsp_count_in = count_ext[srw_pkg::CNT_W-1:0];
      rsp_full_in  = (count_ff >= eff_size);
      rsp_empty_in = (count_ff == '0);
      rsp_hit_in   = 1'b0;
      rsp_moved_in = '0;
      rsp_rv_in    = 1'b0;
      rsp_rs_in    = '0;
      rsp_last_in  = 1'b1;

      case (state_ff)
         srw_pkg::ST_IDLE: begin
            // take the item in and clear the per-item status
            op_in    = srw_pkg::op_type'(req_ch.op);
            seq_in   = req_ch.seq;
            hit_in   = 1'b0;
            moved_in = '0;
            walk_in  = '0;
            pend_in  = 1'b0;
         end
         srw_pkg::ST_DECODE: begin
            // window test without wrap: head <= seq and seq - head <= size - 1
            dist_in = diff;
            win_in  = (seq_ff >= head_ff) && (diff <= srw_pkg::SEQ_W'(eff_m1));
            if (op_ff == srw_pkg::OP_RESET) begin
               head_in  = init_ff;
               front_in = '0;
               count_in = '0;
            end
         end
         srw_pkg::ST_EXEC: begin
            case (op_ff)
               srw_pkg::OP_PUSH: begin
                  // append an unacknowledged entry behind the last one
                  if (count_ff < eff_size) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                     hit_in   = 1'b1;
                  end
               end
               srw_pkg::OP_MARK: begin
                  if (win_ff && (dist_small < count_ff)) begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_add(front_ff, dist_small);
                     mem_wdata = 1'b1;
                     hit_in    = 1'b1;
                  end
               end
               srw_pkg::OP_ADVANCE: begin
                  // pop up to seq at once: no flag needs touching on a pop
                  if (win_ff) begin
                     hit_in   = 1'b1;
                     head_in  = head_ff + srw_pkg::SEQ_W'(adv_n);
                     front_in = slot_add(front_ff, adv_n);
                     count_in = count_ff - adv_n;
                     moved_in = adv_n;
                  end
               end
               default: ;
            endcase
         end
         srw_pkg::ST_STATUS: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_moved_in = moved_ext[srw_pkg::CNT_W-1:0];
            end
         end
         srw_pkg::ST_SLIDE_RD: begin
            if (count_ff != '0) begin
               mem_re = 1'b1;
            end
         end
         srw_pkg::ST_SLIDE_CHK: begin
            if (rd_flag_ff) begin
               front_in = slot_add(front_ff, CW'(1));
               count_in = count_ff - CW'(1);
               head_in  = head_ff + srw_pkg::SEQ_W'(1);
               moved_in = moved_ff + CW'(1);
            end
         end
         srw_pkg::ST_FILL: begin
            // one unacknowledged entry per cycle until the window is full
            if (count_ff < eff_size) begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         srw_pkg::ST_LIST_RD: begin
            if (walk_ff != count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = slot_add(front_ff, walk_ff);
            end
         end
         srw_pkg::ST_LIST_CHK: begin
            if (rd_flag_ff) begin
               walk_in = walk_ff + CW'(1);
            end else if (!pend_ff || out_free) begin
               // a later unacknowledged entry exists, so the held one is not last
               if (pend_ff) begin
                  rsp_load    = 1'b1;
                  rsp_rv_in   = 1'b1;
                  rsp_rs_in   = pend_seq_ff;
                  rsp_last_in = 1'b0;
               end
               pend_in     = 1'b1;
               pend_seq_in = head_ff + srw_pkg::SEQ_W'(walk_ff);
               walk_in     = walk_ff + CW'(1);
            end
         end
         srw_pkg::ST_LIST_END: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               rsp_rv_in = pend_ff;
               rsp_rs_in = pend_ff ? pend_seq_ff : '0;
            end
         end
         default: ;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srw_pkg::ST_IDLE;
         head_ff      <= '0;
         front_ff     <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         moved_ff     <= '0;
         walk_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         moved_ff     <= moved_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      seq_ff      <= seq_in;
      dist_ff     <= dist_in;
      win_ff      <= win_in;
      pend_seq_ff <= pend_seq_in;
      if (rsp_load) begin
         rsp_head_ff  <= rsp_head_in;
         rsp_count_ff <= rsp_count_in;
         rsp_full_ff  <= rsp_full_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_moved_ff <= rsp_moved_in;
         rsp_rv_ff    <= rsp_rv_in;
         rsp_rs_ff    <= rsp_rs_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.head_seq        = rsp_head_ff;
   assign rsp_ch.entry_count     = rsp_count_ff;
   assign rsp_ch.is_full         = rsp_full_ff;
   assign rsp_ch.is_empty        = rsp_empty_ff;
   assign rsp_ch.hit             = rsp_hit_ff;
   assign rsp_ch.moved           = rsp_moved_ff;
   assign rsp_ch.resend_valid    = rsp_rv_ff;
   assign rsp_ch.resend_sequence = rsp_rs_ff;
   assign rsp_ch.last            = rsp_last_ff;

`ifndef ASSERT_OFF
   // the ring never holds more entries than it has slots
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_WINDOW))
      else $error("entry count exceeds ring size");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !rsp_load)
      else $error("result register overwritten while stalled");

   // on entering a flag check, the read was issued in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == srw_pkg::ST_SLIDE_CHK ||
       (state_ff == srw_pkg::ST_LIST_CHK && $past(state_ff) != srw_pkg::ST_LIST_CHK)) |->
      $past(mem_re))
      else $error("flag checked without a read in flight");

   // the final result of an item returns the block to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == srw_pkg::ST_IDLE))
      else $error("last result sent but item still in work");
`endif

endmodule

`default_nettype wire

/* tb/selective_repeat_window_test.sv */
`timescale 1ns / 1ps

module selective_repeat_window_test;

   localparam int MAX_WINDOW = 32;

   // unused op codes: the block must answer with a plain status
   localparam logic [srw_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [srw_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;

   typedef struct {
      logic [srw_pkg::SEQ_W-1:0] head_seq;
      logic [srw_pkg::CNT_W-1:0] entry_count;
      logic                      is_full;
      logic                      is_empty;
      logic                      hit;
      logic [srw_pkg::CNT_W-1:0] moved;
      logic                      resend_valid;
      logic [srw_pkg::SEQ_W-1:0] resend_sequence;
      logic                      last;
   } status_type;

   // one directed item; when typed is set the status result is given here
   typedef struct {
      logic [srw_pkg::OP_W-1:0]  op;
      logic [srw_pkg::SEQ_W-1:0] seq;
      bit                        typed;
      logic [srw_pkg::SEQ_W-1:0] head;
      logic [srw_pkg::CNT_W-1:0] count;
      logic                      full;
      logic                      empty;
      logic                      hit;
   } directed_row_type;

   typedef struct {
      logic [srw_pkg::WS_W-1:0]  window_size;
      logic [srw_pkg::SEQ_W-1:0] initial_sequence;
      bit                        refill;
      int                        send_idle;
      int                        rsp_idle;
      bit                        open_reset;
      bit                        close_reset;
      bit                        hold_off;
      int                        items;
   } phase_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [srw_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [srw_pkg::CSR_DATA_W-1:0] csr_wdata;

   srw_req_if req_bus();
   srw_rsp_if rsp_bus();

   selective_repeat_window #(
      .MAX_WINDOW(MAX_WINDOW)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the window and its registers
   logic [srw_pkg::WS_W-1:0]  cfg_window_size  = 6'd32;
   logic [srw_pkg::SEQ_W-1:0] cfg_initial_seq  = '0;
   bit                        cfg_refill       = 1'b0;
   logic [srw_pkg::SEQ_W-1:0] head_model       = '0;
   int                        front_model      = 0;
   int                        count_model      = 0;
   bit                        acked_model [MAX_WINDOW];

   status_type expected_rsp [$];
   int fail_count    = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_asked    = 0;
   int hold_taken    = 0;

   // Directed items, window of 32, initial sequence 0, no refill.
   directed_row_type directed_rows [25] = '{
      '{srw_pkg::OP_LIST,    32'd0,         1'b1, 32'd0, 6'd0,  1'b0, 1'b1, 1'b0},
      '{srw_pkg::OP_SLIDE,   32'd0,         1'b1, 32'd0, 6'd0,  1'b0, 1'b1, 1'b0},
      '{srw_pkg::OP_MARK,    32'd0,         1'b1, 32'd0, 6'd0,  1'b0, 1'b1, 1'b0},
      '{srw_pkg::OP_ADVANCE, 32'hFFFF_FFFF, 1'b1, 32'd0, 6'd0,  1'b0, 1'b1, 1'b0},
      '{srw_pkg::OP_ADVANCE, 32'd5,         1'b1, 32'd0, 6'd0,  1'b0, 1'b1, 1'b1},
      '{OP_SPARE_6,          32'hFFFF_FFFF, 1'b1, 32'd0, 6'd0,  1'b0, 1'b1, 1'b0},
      '{OP_SPARE_7,          32'd0,         1'b1, 32'd0, 6'd0,  1'b0, 1'b1, 1'b0},
      '{srw_pkg::OP_PUSH,    32'd0,         1'b1, 32'd0, 6'd1,  1'b0, 1'b0, 1'b1},
      '{srw_pkg::OP_PUSH,    32'hFFFF_FFFF, 1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_PUSH,    32'd0,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_PUSH,    32'd0,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_MARK,    32'd1,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_MARK,    32'd0,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_MARK,    32'd3,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_MARK,    32'd32,        1'b1, 32'd0, 6'd4,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_LIST,    32'd0,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_SLIDE,   32'd0,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_ADVANCE, 32'd34,        1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_ADVANCE, 32'd33,        1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_RESET,   32'd0,         1'b1, 32'd0, 6'd32, 1'b1, 1'b0, 1'b0},
      '{srw_pkg::OP_PUSH,    32'd0,         1'b1, 32'd0, 6'd32, 1'b1, 1'b0, 1'b0},
      '{srw_pkg::OP_MARK,    32'd31,        1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_LIST,    32'd0,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_ADVANCE, 32'd31,        1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0},
      '{srw_pkg::OP_SLIDE,   32'd0,         1'b0, 32'd0, 6'd0,  1'b0, 1'b0, 1'b0}
   };

   phase_type phases [6];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Clamp the size register: zero acts as one, anything above the ring acts as the ring.
   function automatic int effective_size();
      if (cfg_window_size == 0) return 1;
      if (cfg_window_size > MAX_WINDOW) return MAX_WINDOW;
      return int'(cfg_window_size);
   endfunction

   function automatic int slot_of(int k);
      return (front_model + k) % MAX_WINDOW;
   endfunction

   function automatic status_type window_status(bit hit, int moved, bit resend,
                                                logic [srw_pkg::SEQ_W-1:0] resend_seq,
                                                bit last);
      status_type s;
      s.head_seq        = head_model;
      s.entry_count     = srw_pkg::CNT_W'(count_model);
      s.is_full         = count_model >= effective_size();
      s.is_empty        = count_model == 0;
      s.hit             = hit;
      s.moved           = srw_pkg::CNT_W'(moved);
      s.resend_valid    = resend;
      s.resend_sequence = resend_seq;
      s.last            = last;
      return s;
   endfunction

   // Queue one predicted result at the tail.
   function automatic void post_result(status_type s);
      expected_rsp.insert(expected_rsp.size(), s);
   endfunction

   // Apply one operation to the shadow window and queue the results it causes.
   function automatic void window_step(logic [srw_pkg::OP_W-1:0] op,
                                       logic [srw_pkg::SEQ_W-1:0] seq);
      bit                        hit;
      bit                        in_win;
      int                        moved;
      int                        listed;
      logic [srw_pkg::SEQ_W:0]   top_seq;
      logic [srw_pkg::SEQ_W-1:0] offset;
      hit     = 1'b0;
      moved   = 0;
      listed  = 0;
      // window test without wrap: head <= seq <= head + size - 1
      top_seq = {1'b0, head_model} + (srw_pkg::SEQ_W + 1)'(effective_size() - 1);
      in_win  = ({1'b0, seq} >= {1'b0, head_model}) && ({1'b0, seq} <= top_seq);
      offset  = seq - head_model;
      case (op)
         srw_pkg::OP_PUSH: begin
            if (count_model < effective_size()) begin
               acked_model[slot_of(count_model)] = 1'b0;
               count_model++;
               hit = 1'b1;
            end
         end
         srw_pkg::OP_MARK: begin
            // marks past the held entries are dropped
            if (in_win && offset < count_model) begin
               acked_model[slot_of(int'(offset))] = 1'b1;
               hit = 1'b1;
            end
         end
         srw_pkg::OP_ADVANCE: begin
            if (in_win) begin
               hit = 1'b1;
               while (count_model > 0 && head_model < seq) begin
                  acked_model[front_model] = 1'b0;
                  front_model = (front_model + 1) % MAX_WINDOW;
                  count_model--;
                  head_model++;
                  moved++;
               end
            end
         end
         srw_pkg::OP_SLIDE: begin
            while (count_model > 0 && acked_model[front_model]) begin
               acked_model[front_model] = 1'b0;
               front_model = (front_model + 1) % MAX_WINDOW;
               count_model--;
               head_model++;
               moved++;
            end
            if (cfg_refill) begin
               while (count_model < effective_size()) begin
                  acked_model[slot_of(count_model)] = 1'b0;
                  count_model++;
               end
            end
         end
         srw_pkg::OP_LIST: begin
            for (int k = 0; k < count_model; k++) begin
               if (!acked_model[slot_of(k)]) begin
                  post_result(window_status(1'b0, 0, 1'b1, head_model + k, 1'b0));
                  listed++;
               end
            end
            // nothing to resend still answers once
            if (listed == 0) post_result(window_status(1'b0, 0, 1'b0, '0, 1'b1));
            else expected_rsp[expected_rsp.size() - 1].last = 1'b1;
            return;
         end
         srw_pkg::OP_RESET: begin
            for (int k = 0; k < MAX_WINDOW; k++) acked_model[k] = 1'b0;
            front_model = 0;
            count_model = 0;
            head_model  = cfg_initial_seq;
            while (count_model < effective_size()) begin
               acked_model[slot_of(count_model)] = 1'b0;
               count_model++;
            end
         end
         default: begin
         end
      endcase
      post_result(window_status(hit, moved, 1'b0, '0, 1'b1));
   endfunction

   function automatic void check_field(string name, logic [srw_pkg::SEQ_W-1:0] want,
                                       logic [srw_pkg::SEQ_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Offer one item, idling first at the sender's rate, and predict once it transfers.
   task automatic send_item(input logic [srw_pkg::OP_W-1:0] op,
                            input logic [srw_pkg::SEQ_W-1:0] seq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.seq   <= seq;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      window_step(op, seq);
   endtask

   task automatic wait_idle();
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Write every register, one per edge; lower the enable once after the last.
   task automatic load_config(input logic [srw_pkg::WS_W-1:0] size,
                              input logic [srw_pkg::SEQ_W-1:0] start_seq,
                              input bit refill);
      csr_we    <= 1'b1;
      csr_index <= srw_pkg::CSR_WINDOW_SIZE;
      csr_wdata <= srw_pkg::CSR_DATA_W'(size);
      @(posedge clock);
      cfg_window_size = size;
      csr_index <= srw_pkg::CSR_INITIAL_SEQUENCE;
      csr_wdata <= start_seq;
      @(posedge clock);
      cfg_initial_seq = start_seq;
      csr_index <= srw_pkg::CSR_REFILL_ON_SLIDE;
      csr_wdata <= srw_pkg::CSR_DATA_W'(refill);
      @(posedge clock);
      cfg_refill = refill;
      csr_we <= 1'b0;
   endtask

   // Result side: check every transfer, then pick ready for the next edge.
   initial begin : receiver
      status_type want;
      status_type got;
      int         hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.head_seq, rsp_bus.entry_count, rsp_bus.is_full, rsp_bus.is_empty,
                    rsp_bus.hit, rsp_bus.moved, rsp_bus.resend_valid,
                    rsp_bus.resend_sequence, rsp_bus.last};
            if (expected_rsp.size() == 0) begin
               $error("result transfer with nothing pending: head_seq %0h", got.head_seq);
               fail_count++;
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               check_field("head_seq", want.head_seq, got.head_seq);
               check_field("entry_count", want.entry_count, got.entry_count);
               check_field("is_full", want.is_full, got.is_full);
               check_field("is_empty", want.is_empty, got.is_empty);
               check_field("hit", want.hit, got.hit);
               check_field("moved", want.moved, got.moved);
               check_field("resend_valid", want.resend_valid, got.resend_valid);
               check_field("resend_sequence", want.resend_sequence, got.resend_sequence);
               check_field("last", want.last, got.last);
            end
         end
         // start a long hold-off when one is asked for, so the block backs up
         if (hold_left == 0 && hold_taken != hold_asked) begin
            hold_taken++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : stimulus
      logic [srw_pkg::OP_W-1:0]  op_code;
      logic [srw_pkg::SEQ_W-1:0] seq;
      int                        pick;
      int                        last_idx;
      // drive every input to a known value before the first edge
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.op    = '0;
      req_bus.seq   = '0;
      for (int k = 0; k < MAX_WINDOW; k++) acked_model[k] = 1'b0;

      // Settings walked by the random part: size extremes (zero, one, full ring and
      // beyond it), initial sequence at both ends so the head wraps, both slide modes.
      phases[0] = '{6'd32, 32'd0,         1'b1, 12, 63, 1'b1, 1'b0, 1'b0, 30};
      phases[1] = '{6'd1,  32'hFFFF_FFF0, 1'b1, 12, 63, 1'b1, 1'b0, 1'b0, 20};
      phases[2] = '{6'd0,  $urandom,      1'b0, 63, 12, 1'b1, 1'b0, 1'b0, 20};
      // leave the ring full so the next, smaller size sees more entries than its window holds
      phases[3] = '{6'd63, 32'hFFFF_FFFF, 1'b1, 63, 12, 1'b1, 1'b1, 1'b0, 30};
      phases[4] = '{srw_pkg::WS_W'($urandom_range(3, 31)), $urandom, 1'($urandom_range(1)),
                    0, 0, 1'b0, 1'b0, 1'b1, 30};
      phases[5] = '{6'd7,  32'd0,         1'b0, 0, 0, 1'b0, 1'b0, 1'b0, 20};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      send_idle_pct = 12;
      rsp_idle_pct  = 63;
      load_config(6'd32, 32'd0, 1'b0);
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].seq);
         if (directed_rows[i].typed) begin
            last_idx = expected_rsp.size() - 1;
            expected_rsp[last_idx] = '{directed_rows[i].head, directed_rows[i].count,
                                       directed_rows[i].full, directed_rows[i].empty,
                                       directed_rows[i].hit, '0, 1'b0, '0, 1'b1};
         end
      end
      req_bus.valid <= 1'b0;
      wait_idle();

      // random part
      foreach (phases[p]) begin
         load_config(phases[p].window_size, phases[p].initial_sequence, phases[p].refill);
         send_idle_pct = phases[p].send_idle;
         rsp_idle_pct  = phases[p].rsp_idle;
         if (phases[p].hold_off) hold_asked++;
         if (phases[p].open_reset) send_item(srw_pkg::OP_RESET, $urandom);
         for (int n = 0; n < phases[p].items; n++) begin
            pick = $urandom_range(99);
            seq  = $urandom;
            if (pick < 22) op_code = srw_pkg::OP_PUSH;
            else if (pick < 52) op_code = srw_pkg::OP_MARK;
            else if (pick < 62) op_code = srw_pkg::OP_ADVANCE;
            else if (pick < 77) op_code = srw_pkg::OP_SLIDE;
            else if (pick < 87) op_code = srw_pkg::OP_LIST;
            else if (pick < 94) op_code = srw_pkg::OP_RESET;
            else op_code = srw_pkg::OP_W'($urandom_range(7));
            // aim most sequence numbers at the window and just past its edges
            if (op_code == srw_pkg::OP_MARK || op_code == srw_pkg::OP_ADVANCE) begin
               pick = $urandom_range(99);
               if (pick < 80) seq = head_model + $urandom_range(effective_size());
               else if (pick < 90) seq = head_model - $urandom_range(1, 4);
            end
            send_item(op_code, seq);
         end
         if (phases[p].close_reset) send_item(srw_pkg::OP_RESET, $urandom);
         req_bus.valid <= 1'b0;
         wait_idle();
      end

      // let any stray result show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
